/* sv/rmst_pkg.sv */
// Package with the shared constants, types and state codes of the range-maximum segment tree.
`timescale 1ns / 1ps

package rmst_pkg;

  // Tree geometry: leaves occupy nodes SIZE .. 2*SIZE-1, the root is node 1.
  localparam int SIZE     = 1024;
  localparam int NODE_CNT = 2 * SIZE;
  localparam int NODE_AW  = $clog2(NODE_CNT);
  // Node index wide enough to hold NODE_CNT itself (query right bound is exclusive).
  localparam int IDX_W    = NODE_AW + 1;

  // Fixed field widths.
  localparam int POS_W = 11;
  localparam int VAL_W = 32;

  localparam logic [POS_W-1:0] ACTIVE_RST = 11'd1024;

  // Item kinds.
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef logic [NODE_AW-1:0] node_addr_t;
  typedef logic [VAL_W-1:0]   node_val_t;

  // Request from the sequencer to the node memory.
  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    node_val_t  wdata;
    node_addr_t raddr;
  } mem_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_UPD_UP,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_RESULT
  } seq_state_t;

endpackage

/* sv/rmst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rmst_max.sv */
// Shared unsigned maximum unit used by both the update climb and the query scan.
`timescale 1ns / 1ps

module rmst_max
  import rmst_pkg::*;
(
  input  node_val_t a,
  input  node_val_t b,
  output node_val_t y
);

  // Single magnitude compare and select.
  assign y = (a > b) ? a : b;

endmodule

/* sv/rmst_seq.sv */
// Sequencer and datapath that walk the tree for updates, queries and the clearing pass.
`timescale 1ns / 1ps

module rmst_seq
  import rmst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [POS_W-1:0] active_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [POS_W-1:0] in_position,
  input  node_val_t        in_value,
  input  logic [POS_W-1:0] in_range_low,
  input  logic [POS_W-1:0] in_range_high,
  output logic             out_valid,
  input  logic             out_ready,
  output node_val_t        out_max_value,
  output logic             out_status,
  output mem_req_t         mem_req,
  input  node_val_t        mem_rdata
);

  seq_state_t       state_r, state_nxt;
  node_addr_t       clr_r, clr_nxt;
  node_addr_t       k_r, k_nxt;
  node_val_t        cur_r, cur_nxt;
  node_val_t        best_r, best_nxt;
  logic [IDX_W-1:0] l_r, l_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic             pend_r, pend_nxt;
  logic             status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  node_val_t        out_max_r, out_max_nxt;
  logic             out_status_r, out_status_nxt;

  logic             accept;
  logic [POS_W-1:0] eff;
  logic             upd_ok;
  logic [POS_W-1:0] lo_c;
  logic [POS_W-1:0] hi_c;
  logic             q_empty;
  node_addr_t       k_up;
  logic [IDX_W-1:0] r_dec;
  logic             out_room;
  node_val_t        max_b;
  node_val_t        max_y;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_room = !out_valid_r || out_ready;

  // Effective size, update range check and clipped query bounds.
  assign eff     = (32'(active_count) > 32'(SIZE)) ? POS_W'(SIZE) : active_count;
  assign upd_ok  = (in_position != '0) && (in_position <= eff);
  assign lo_c    = (in_range_low == '0) ? POS_W'(1) : in_range_low;
  assign hi_c    = (in_range_high > eff) ? eff : in_range_high;
  assign q_empty = (hi_c < lo_c);

  assign k_up  = k_r >> 1;
  assign r_dec = r_r - IDX_W'(1);

  // The memory read data is always one operand of the shared maximum unit.
  assign max_b = ((state_r == S_Q_LEFT) || (state_r == S_Q_RIGHT)) ? best_r : cur_r;

  rmst_max u_max (
    .a (mem_rdata),
    .b (max_b),
    .y (max_y)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == NODE_AW'(NODE_CNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_UPDATE) begin
            state_nxt = upd_ok ? S_UPD_RD : S_RESULT;
          end else begin
            state_nxt = q_empty ? S_RESULT : S_Q_LEFT;
          end
        end
      end
      S_UPD_RD:  state_nxt = S_UPD_WR;
      S_UPD_WR:  state_nxt = S_UPD_UP;
      S_UPD_UP: begin
        if (k_up == NODE_AW'(1)) begin
          state_nxt = S_RESULT;
        end
      end
      S_Q_LEFT: begin
        state_nxt = (l_r >= r_r) ? S_RESULT : S_Q_RIGHT;
      end
      S_Q_RIGHT: state_nxt = S_Q_LEFT;
      S_RESULT: begin
        if (out_room) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_CLEAR;
    endcase
  end

  // Datapath, memory requests and result register.
  always_comb begin
    clr_nxt        = clr_r;
    k_nxt          = k_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    pend_nxt       = 1'b0;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_max_nxt    = out_max_r;
    out_status_nxt = out_status_r;
    mem_req        = '0;

    // Query partial maxima arrive in the cycle after their read.
    if (pend_r) begin
      best_nxt = max_y;
    end

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + NODE_AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          best_nxt = '0;
          cur_nxt  = in_value;
          k_nxt    = NODE_AW'(32'(SIZE) + 32'(in_position) - 32'd1);
          l_nxt    = IDX_W'(32'(SIZE) + 32'(lo_c) - 32'd1);
          r_nxt    = IDX_W'(32'(SIZE) + 32'(hi_c));
          if ((in_mode == MODE_UPDATE) && !upd_ok) begin
            status_nxt = STATUS_RANGE;
          end else begin
            status_nxt = STATUS_OK;
          end
        end
      end
      S_UPD_RD: begin
        mem_req.raddr = k_r;
      end
      S_UPD_WR: begin
        // Merge the new value into the leaf and fetch its sibling.
        mem_req.we    = 1'b1;
        mem_req.waddr = k_r;
        mem_req.wdata = max_y;
        mem_req.raddr = k_r ^ NODE_AW'(1);
        cur_nxt       = max_y;
      end
      S_UPD_UP: begin
        // Parent is the larger of the refreshed child and its sibling.
        mem_req.we    = 1'b1;
        mem_req.waddr = k_up;
        mem_req.wdata = max_y;
        mem_req.raddr = k_up ^ NODE_AW'(1);
        cur_nxt       = max_y;
        k_nxt         = k_up;
      end
      S_Q_LEFT: begin
        if ((l_r < r_r) && l_r[0]) begin
          mem_req.raddr = l_r[NODE_AW-1:0];
          pend_nxt      = 1'b1;
          l_nxt         = l_r + IDX_W'(1);
        end
      end
      S_Q_RIGHT: begin
        if (r_r[0]) begin
          mem_req.raddr = r_dec[NODE_AW-1:0];
          pend_nxt      = 1'b1;
        end
        l_nxt = l_r >> 1;
        r_nxt = r_r >> 1;
      end
      S_RESULT: begin
        if (out_room) begin
          out_valid_nxt  = 1'b1;
          out_max_nxt    = best_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    l_r          <= l_nxt;
    r_r          <= r_nxt;
    status_r     <= status_nxt;
    out_max_r    <= out_max_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_r;
  assign out_status    = out_status_r;

  // The node memory is only written by the clearing pass and by updates.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_CLEAR || state_r == S_UPD_WR || state_r == S_UPD_UP))
    else $error("node memory written outside clear or update");

  // The climb never goes above the root.
  a_climb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD_UP) |-> (k_r > NODE_AW'(1)))
    else $error("update climb passed the root");

  // A flagged update always reports a zero maximum.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_RANGE) |-> (out_max_value == '0))
    else $error("flagged result carries a non-zero maximum");

  // The query scan keeps its exclusive bound inside the node space.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_LEFT || state_r == S_Q_RIGHT) |-> (r_r <= IDX_W'(NODE_CNT)))
    else $error("query bound beyond node space");

  // No item is taken before the clearing pass has finished.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

endmodule

/* sv/range_max_segment_tree_top.sv */
// Top level of the range-maximum segment tree: size register, sequencer and node memory.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready| cfg_active_count
//  in      | in        | in_valid/in_ready  | in_mode, in_position, in_value, in_range_*
//  out     | out       | out_valid/out_ready| out_max_value, out_status
//
// An update reads its leaf, then writes one node per tree level through the single write
// port; a query scans a left and a right state at each level, bounded by the read port.
// After reset a clearing pass writes zero to all 2048 nodes, one per cycle; no item is
// accepted during the pass, but configuration transfers are taken at any time.
// A finished result waits in an output register, so the next item may be accepted while
// the consumer stalls; a further result then waits until that register is free.
`timescale 1ns / 1ps

module range_max_segment_tree_top
  import rmst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_active_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0] in_range_low,
  input  logic [POS_W-1:0] in_range_high,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_max_value,
  output logic             out_status
);

  logic [POS_W-1:0] active_r, active_nxt;
  mem_req_t         mem_req;
  node_val_t        mem_rdata;

  // Size register: every transfer on the configuration channel writes it.
  assign cfg_ready  = 1'b1;
  assign active_nxt = (cfg_valid && cfg_ready) ? cfg_active_count : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Tree walking sequencer.
  rmst_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .active_count  (active_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_value (out_max_value),
    .out_status    (out_status),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // Node maxima store.
  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODE_CNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

/* tb/rmst_checker.sv */
// Checker for the range-maximum segment tree: it mirrors the node maxima and compares every result.
`timescale 1ns / 1ps

module rmst_checker
  import rmst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_active_count,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_mode,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0] in_range_low,
  input  logic [POS_W-1:0] in_range_high,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [VAL_W-1:0] out_max_value,
  input  logic             out_status,
  input  logic             run_done,
  output int               fail_count,
  output int               owed_count
);

  typedef struct packed {
    logic [VAL_W-1:0] max_value;
    logic             status;
  } tree_result_t;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int SHOWN_MAX = 40;

  logic [VAL_W-1:0] node_max [NODE_CNT];
  logic [POS_W-1:0] span;
  tree_result_t     owed_results [$];
  int               mismatches = 0;
  bit               leftovers_done = 1'b0;

  // Positions in use; a register value above the tree size acts as the tree size.
  function automatic int unsigned live_size();
    return (32'(span) > 32'(SIZE)) ? 32'(SIZE) : 32'(span);
  endfunction

  function automatic logic [VAL_W-1:0] bigger(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Merge a value into its leaf and refresh every node on the path to the root.
  task automatic merge_at_position(input int unsigned pos, input logic [VAL_W-1:0] val);
    int unsigned k;
    k = SIZE + pos - 1;
    node_max[k] = bigger(node_max[k], val);
    while (k > 1) begin
      k = k >> 1;
      node_max[k] = bigger(node_max[2*k], node_max[2*k+1]);
    end
  endtask

  // Maximum over the clipped inclusive range, walked bottom-up as a half-open node interval.
  function automatic logic [VAL_W-1:0] range_maximum(input int unsigned lo, input int unsigned hi);
    int unsigned      l;
    int unsigned      r;
    logic [VAL_W-1:0] best;
    best = '0;
    if (lo < 1) lo = 1;
    if (hi > live_size()) hi = live_size();
    if (hi >= lo) begin
      l = SIZE + lo - 1;
      r = SIZE + hi;
      while (l < r) begin
        if (l[0]) begin
          best = bigger(best, node_max[l]);
          l++;
        end
        if (r[0]) begin
          r--;
          best = bigger(best, node_max[r]);
        end
        l = l >> 1;
        r = r >> 1;
      end
    end
    return best;
  endfunction

  task automatic report(input string what, input logic [VAL_W-1:0] want,
                        input logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t ns: mismatch in %s: expected %0h, observed %0h", $time, what, want, got);
  endtask

  // Watch all three channels at each edge; results are matched before new items are queued.
  always @(posedge clk) begin : watch
    tree_result_t want;
    if (!rst_n) begin
      foreach (node_max[i]) node_max[i] = '0;
      span = ACTIVE_RST;
      owed_results.delete();
    end else begin
      // A configuration transfer takes effect for items accepted afterwards.
      if (cfg_valid && cfg_ready) span = cfg_active_count;

      // Compare a delivered result with the oldest one owed.
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          report("unexpected result", '0, out_max_value);
        end else begin
          want = owed_results.pop_front();
          if (out_max_value !== want.max_value) report("max_value", want.max_value, out_max_value);
          if (out_status !== want.status) begin
            report("status", VAL_W'(want.status), VAL_W'(out_status));
          end
        end
      end

      // Predict the result of an accepted item.
      if (in_valid && in_ready) begin
        want.max_value = '0;
        want.status    = STATUS_OK;
        if (in_mode == MODE_QUERY) begin
          want.max_value = range_maximum(32'(in_range_low), 32'(in_range_high));
        end else if (in_position < 1 || 32'(in_position) > live_size()) begin
          want.status = STATUS_RANGE;
        end else begin
          merge_at_position(32'(in_position), in_value);
        end
        owed_results = {owed_results, want};
      end

      // At the end of the run every result still owed is a failure.
      if (run_done && !leftovers_done) begin
        leftovers_done = 1'b1;
        foreach (owed_results[i]) report("missing result", owed_results[i].max_value, '0);
        owed_results.delete();
      end
    end
    fail_count <= mismatches;
    owed_count <= owed_results.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the testbench: clock, reset, stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import rmst_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int PHASES       = 9;
  localparam int POS_TOP      = (1 << POS_W) - 1;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SELDOM,
    READY_PERIODIC
  } stall_style_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_active_count = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_mode = MODE_UPDATE;
  logic [POS_W-1:0] in_position = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0] in_range_low = '0;
  logic [POS_W-1:0] in_range_high = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_max_value;
  logic             out_status;
  logic             run_done = 1'b0;
  int               fail_count;
  int               owed_count;

  // Sender bookkeeping.
  bit               valid_up = 1'b0;
  bit               gap_free = 1'b0;
  int               burst_left = 0;
  int unsigned      live = SIZE;
  int               n_update = 0;
  int               n_query = 0;
  int               n_rejected = 0;
  int               n_configs = 0;

  // Register settings of the random phases and the number of items in each.
  int unsigned phase_span  [PHASES] = '{1024, 16, 2047, 300, 1, 1024, 0, 700, 1024};
  int          phase_items [PHASES] = '{300, 250, 250, 250, 80, 250, 60, 250, 160};

  range_max_segment_tree_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_count (cfg_active_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_value         (in_value),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_max_value    (out_max_value),
    .out_status       (out_status)
  );

  rmst_checker i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_count (cfg_active_count),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_value         (in_value),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_max_value    (out_max_value),
    .out_status       (out_status),
    .run_done         (run_done),
    .fail_count       (fail_count),
    .owed_count       (owed_count)
  );

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  // Give up if the run does not finish within a generous number of cycles.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles without finishing", CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // The consumer stalls in styles that are picked anew at random, one after another.
  initial begin : consumer
    stall_style_t style;
    int           period;
    forever begin
      style  = stall_style_t'($urandom_range(0, 3));
      period = $urandom_range(2, 9);
      for (int c = 0; c < 300; c++) begin
        @(posedge clk);
        case (style)
          READY_ALWAYS:   out_ready <= 1'b1;
          READY_MOSTLY:   out_ready <= ($urandom_range(0, 9) != 0);
          READY_SELDOM:   out_ready <= ($urandom_range(0, 3) == 0);
          default:        out_ready <= ((c % period) >= period / 2);
        endcase
      end
    end
  end

  // Present one item, wait for its transfer, then perhaps leave a gap before the next.
  task automatic put(input logic mode, input logic [POS_W-1:0] pos,
                     input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                     input logic [POS_W-1:0] hi);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_position   <= pos;
    in_value      <= val;
    in_range_low  <= lo;
    in_range_high <= hi;
    valid_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (mode == MODE_QUERY) begin
      n_query++;
    end else begin
      n_update++;
      if (pos < 1 || 32'(pos) > live) n_rejected++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else if (!gap_free) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Hold the sender until every owed result has come and the block has gone quiet.
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
    do @(posedge clk); while (owed_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_span(input logic [POS_W-1:0] span);
    settle();
    cfg_valid        <= 1'b1;
    cfg_active_count <= span;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live = (32'(span) > 32'(SIZE)) ? 32'(SIZE) : 32'(span);
    n_configs++;
  endtask

  // Mostly narrow values so that maxima stay distinguishable, with full-width ones now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] mask;
    mask = (32'h1 << $urandom_range(0, 31)) - 32'h1;
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom & mask;
  endfunction

  // One random item: mostly in-range positions and short ranges, plus edges and noise.
  task automatic random_item();
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    int unsigned      top_pos;
    top_pos = (live == 0) ? 1 : live;
    pos = POS_W'($urandom_range(1, top_pos));
    case ($urandom_range(0, 9))
      0:       pos = '0;
      1:       pos = POS_W'($urandom_range(0, POS_TOP));
      2:       pos = POS_W'(top_pos);
      default: ;
    endcase
    lo = POS_W'($urandom_range(1, top_pos));
    hi = lo + POS_W'($urandom_range(0, 6));
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = POS_W'($urandom_range(0, POS_TOP));
        hi = POS_W'($urandom_range(0, POS_TOP));
      end
      2: begin
        lo = '0;
        hi = POS_W'($urandom_range(top_pos, POS_TOP));
      end
      3:       hi = lo - POS_W'(1);
      4, 5:    hi = lo + POS_W'($urandom_range(0, 200));
      default: ;
    endcase
    put($urandom_range(0, 1) ? MODE_QUERY : MODE_UPDATE, pos, pick_value(), lo, hi);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty tree, field extremes, rejected updates and clipped queries.
    set_span(11'd1024);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd1,    11'd1024);
    put(MODE_UPDATE, 11'd1,    32'hFFFF_FFFF,  11'd0,    11'd0);
    put(MODE_UPDATE, 11'd1024, 32'd5,          11'd0,    11'd0);
    put(MODE_UPDATE, 11'd0,    32'd7,          11'd0,    11'd0);
    put(MODE_UPDATE, 11'd1025, 32'd7,          11'd0,    11'd0);
    put(MODE_UPDATE, 11'd2047, 32'd7,          11'd2047, 11'd2047);
    put(MODE_UPDATE, 11'd512,  32'd100,        11'd0,    11'd0);
    put(MODE_UPDATE, 11'd512,  32'd50,         11'd0,    11'd0);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd512,  11'd512);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd0,    11'd2047);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd2,    11'd1023);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd1024, 11'd1024);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd10,   11'd9);
    put(MODE_QUERY,  11'd2047, 32'hFFFF_FFFF,  11'd2047, 11'd2047);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd0,    11'd0);
    // A single active position hides the value stored at the top leaf.
    set_span(11'd1);
    put(MODE_UPDATE, 11'd1,    32'd7,          11'd0,    11'd0);
    put(MODE_UPDATE, 11'd2,    32'd7,          11'd0,    11'd0);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd1,    11'd1024);
    // No active position: every update is rejected and every query is empty.
    set_span(11'd0);
    put(MODE_UPDATE, 11'd1,    32'd3,          11'd0,    11'd0);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd1,    11'd1024);
    // A size above the tree acts as the full tree, and the hidden values reappear.
    set_span(11'd2047);
    put(MODE_UPDATE, 11'd1024, 32'd9,          11'd0,    11'd0);
    put(MODE_QUERY,  11'd0,    32'd0,          11'd1000, 11'd2047);

    // Random part, one phase per register setting; some phases send without gaps.
    for (int p = 0; p < PHASES; p++) begin
      set_span(POS_W'(phase_span[p]));
      gap_free   = (p % 4 == 2);
      burst_left = 0;
      repeat (phase_items[p]) random_item();
    end

    settle();
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    $display("Sent %0d updates (%0d outside the active size) and %0d queries", n_update,
             n_rejected, n_query);
    $display("over %0d size settings from none to beyond the tree, under gaps and stalls",
             n_configs);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rmst_pkg.sv
sv/rmst_ram.sv
sv/rmst_max.sv
sv/rmst_seq.sv
sv/range_max_segment_tree_top.sv
tb/rmst_checker.sv
tb/testbench.sv
